FILE: sv/dscf_pkg.sv
// Shared types, constants and zone table functions for the disk sector chain follower.
package dscf_pkg;

    // Field widths
    localparam int TRACK_W    = 8;
    localparam int SECTOR_W   = 8;
    localparam int INDEX_W    = 10;
    localparam int OFFSET_W   = 18;
    localparam int COUNT_W    = 8;
    localparam int BLOCKS_W   = 10;
    localparam int CAPACITY_W = 18;
    localparam int STATUS_W   = 3;
    localparam int SPT_W      = 5;

    // Disk geometry
    localparam int TRACK_COUNT_DEFAULT = 35;
    localparam int TRACK_COUNT_MAX     = 35;
    localparam int SECTOR_SHIFT        = 8;    // 256 bytes per sector
    localparam int PAYLOAD_MAX         = 254;
    localparam int VISIT_ROW_W         = 32;   // visited bits held per row

    // Operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_LINK  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_FETCH       = 3'd0,
        STATUS_DONE        = 3'd1,
        STATUS_CHAIN_ERROR = 3'd2,
        STATUS_TRUNCATED   = 3'd3,
        STATUS_IDLE        = 3'd4
    } status_t;

    typedef struct packed {
        logic                operation;
        logic [TRACK_W-1:0]  track_byte;
        logic [SECTOR_W-1:0] sector_byte;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] fetch_offset;
        logic [OFFSET_W-1:0] copy_position;
        logic [COUNT_W-1:0]  copy_count;
        logic [OFFSET_W-1:0] total_length;
        logic [BLOCKS_W-1:0] block_count;
        logic                chain_ok;
    } result_t;

    // Outcome of the zone lookup for one track/sector pair
    typedef struct packed {
        logic               in_range;
        logic [INDEX_W-1:0] index;
    } locate_t;

    // Sectors per track of the zone table; 0 for a track outside the disk
    function automatic logic [SPT_W-1:0] zone_spt(input logic [TRACK_W-1:0] t,
                                                  input int track_count);
        logic [SPT_W-1:0] spt;
        if (t == '0 || int'(t) > track_count || int'(t) > TRACK_COUNT_MAX)
            spt = '0;
        else if (t <= 8'd17)
            spt = 5'd21;
        else if (t <= 8'd24)
            spt = 5'd19;
        else if (t <= 8'd30)
            spt = 5'd18;
        else
            spt = 5'd17;
        return spt;
    endfunction

    // Linear index of sector 0 of track t (t counted from 1)
    function automatic int track_base(input int t);
        int base;
        if (t <= 17)
            base = (t - 1) * 21;
        else if (t <= 24)
            base = 357 + (t - 18) * 19;
        else if (t <= 30)
            base = 490 + (t - 25) * 18;
        else
            base = 598 + (t - 31) * 17;
        return base;
    endfunction

endpackage

FILE: sv/dscf_item_if.sv
// Input request channel of the chain follower.
interface dscf_item_if
    import dscf_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/dscf_result_if.sv
// Result channel of the chain follower.
interface dscf_result_if
    import dscf_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/dscf_cfg_if.sv
// Configuration write channel carrying the buffer capacity.
interface dscf_cfg_if
    import dscf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CAPACITY_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/disk_sector_chain_follower.sv
// Top level of the disk sector chain follower: request register, chain logic, result register.
//
// Usage:
//   item   : requests. operation 0 starts a chain at track_byte/sector_byte, operation 1
//            hands in the two link bytes of the sector that was just fetched.
//   result : one result per request: status, offset of the next sector to fetch, where and
//            how many payload bytes (from sector byte 2) to copy, running totals, chain_ok.
//   cfg    : writes buffer_capacity (0 = no limit); always ready, write only when idle.
// An accepted request goes through the chain logic to the result register, held until taken.
// Throughput: one request per cycle; the zone table and the visited bitmap flops are read
//   and updated in the single pass between the request register and the result register.
// Stalls: while the result register is full and result.ready is low, the request register
//   holds its request and item.ready falls; nothing is lost or repeated.
// Reset: the chain is not running, totals are zero, the visited map and the capacity
//   clear at once; requests are taken as soon as reset is released.
module disk_sector_chain_follower
    import dscf_pkg::*;
#(
    parameter int TRACK_COUNT = TRACK_COUNT_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    dscf_item_if.sink     item,
    dscf_result_if.source result,
    dscf_cfg_if.sink      cfg
);

    localparam int SectorTotal = track_base(TRACK_COUNT + 1);

    // Request register
    logic  item_valid_reg;
    item_t item_reg;

    // Chain state
    logic                  running_reg, running_next;
    logic [OFFSET_W-1:0]   position_reg, position_next;
    logic [BLOCKS_W-1:0]   blocks_reg, blocks_next;
    logic [CAPACITY_W-1:0] capacity_reg;

    // Result register
    logic    result_valid_reg;
    result_t result_reg, result_next;

    logic                advance;
    locate_t             loc;
    logic                visited;
    logic                loc_ok;
    logic                map_clear;
    logic                map_mark;
    logic [COUNT_W-1:0]  used;
    logic [OFFSET_W:0]   sum;
    logic                over;
    logic [OFFSET_W-1:0] fetch_at;

    // Handshakes
    assign advance      = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready   = !item_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    // Zone lookup and visited bitmap
    dscf_locate #(
        .TRACK_COUNT  (TRACK_COUNT),
        .SECTOR_TOTAL (SectorTotal)
    ) u_locate (
        .track  (item_reg.track_byte),
        .sector (item_reg.sector_byte),
        .loc    (loc)
    );

    dscf_visited_map #(
        .SECTOR_TOTAL (SectorTotal)
    ) u_visited (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (map_clear),
        .rd_index   (loc.index),
        .rd_visited (visited),
        .wr_en      (map_mark),
        .wr_index   (loc.index)
    );

    // A start clears the map first, so its own sector never counts as visited
    assign loc_ok   = loc.in_range && (item_reg.operation == OP_START || !visited);
    assign fetch_at = {loc.index, SECTOR_SHIFT'(0)};

    // Payload size and overflow check for a link
    always_comb
    begin
        if (item_reg.track_byte != '0)
            used = COUNT_W'(PAYLOAD_MAX);
        else if (item_reg.sector_byte > COUNT_W'(PAYLOAD_MAX))
            used = COUNT_W'(PAYLOAD_MAX);
        else
            used = item_reg.sector_byte;
        sum  = {1'b0, position_reg} + (OFFSET_W + 1)'(used);
        over = (capacity_reg != '0) && (sum > (OFFSET_W + 1)'(capacity_reg));
    end

    // Chain step
    always_comb
    begin
        running_next  = running_reg;
        position_next = position_reg;
        blocks_next   = blocks_reg;
        map_clear     = 1'b0;
        map_mark      = 1'b0;
        result_next   = '0;

        if (item_reg.operation == OP_START)
        begin
            map_clear     = advance;
            position_next = '0;
            blocks_next   = '0;
            running_next  = 1'b0;
            if (item_reg.track_byte == '0)
                result_next.status = STATUS_DONE;
            else if (!loc_ok)
                result_next.status = STATUS_CHAIN_ERROR;
            else
            begin
                map_mark                 = advance;
                running_next             = 1'b1;
                result_next.status       = STATUS_FETCH;
                result_next.fetch_offset = fetch_at;
            end
        end
        else if (!running_reg)
        begin
            result_next.status = STATUS_IDLE;
        end
        else if (over)
        begin
            running_next       = 1'b0;
            result_next.status = STATUS_TRUNCATED;
        end
        else
        begin
            position_next          = sum[OFFSET_W-1:0];
            blocks_next            = blocks_reg + BLOCKS_W'(1);
            result_next.copy_count = used;
            result_next.copy_position = (used == '0) ? '0 : position_reg;
            if (item_reg.track_byte == '0)
            begin
                running_next         = 1'b0;
                result_next.status   = STATUS_DONE;
                result_next.chain_ok = 1'b1;
            end
            else if (!loc_ok)
            begin
                running_next       = 1'b0;
                result_next.status = STATUS_CHAIN_ERROR;
            end
            else
            begin
                map_mark                 = advance;
                result_next.status       = STATUS_FETCH;
                result_next.fetch_offset = fetch_at;
            end
        end

        result_next.total_length = position_next;
        result_next.block_count  = blocks_next;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            running_reg      <= 1'b0;
            position_reg     <= '0;
            blocks_reg       <= '0;
            capacity_reg     <= '0;
        end
        else
        begin
            if (item.valid && item.ready)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (result.ready)
                result_valid_reg <= 1'b0;

            if (advance)
            begin
                running_reg  <= running_next;
                position_reg <= position_next;
                blocks_reg   <= blocks_next;
            end

            if (cfg.valid && cfg.ready)
                capacity_reg <= cfg.data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            item_reg <= item.data;
        if (advance)
            result_reg <= result_next;
    end

endmodule

FILE: sv/dscf_locate.sv
// Zone table lookup: checks a track/sector pair and gives its linear sector index.
module dscf_locate
    import dscf_pkg::*;
#(
    parameter int TRACK_COUNT = TRACK_COUNT_DEFAULT,
    parameter int SECTOR_TOTAL = 683
)
(
    input  logic [TRACK_W-1:0]  track,
    input  logic [SECTOR_W-1:0] sector,
    output locate_t             loc
);

    logic [SPT_W-1:0]   spt;
    logic [INDEX_W-1:0] base;
    logic [INDEX_W:0]   sum;

    // Zone lookup from the constant table
    always_comb
    begin
        spt  = zone_spt(track, TRACK_COUNT);
        base = INDEX_W'(track_base(int'(track)));
        sum  = {1'b0, base} + (INDEX_W + 1)'(sector);
    end

    // Sector must lie inside its track and inside the disk
    always_comb
    begin
        loc.index    = sum[INDEX_W-1:0];
        loc.in_range = (spt != '0) && ({3'b000, sector[SPT_W-1:0]} == sector)
                       && (sector[SPT_W-1:0] < spt)
                       && (sum < (INDEX_W + 1)'(SECTOR_TOTAL));
    end

endmodule

FILE: sv/dscf_visited_map.sv
// Visited sector bitmap held in rows of flops, cleared at once by a chain start.
module dscf_visited_map
    import dscf_pkg::*;
#(
    parameter int SECTOR_TOTAL = 683
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic [INDEX_W-1:0] rd_index,
    output logic               rd_visited,
    input  logic               wr_en,
    input  logic [INDEX_W-1:0] wr_index
);

    localparam int BitW  = $clog2(VISIT_ROW_W);
    localparam int Rows  = (SECTOR_TOTAL + VISIT_ROW_W - 1) / VISIT_ROW_W;
    localparam int RowW  = (Rows > 1) ? $clog2(Rows) : 1;
    localparam int RowHi = INDEX_W - BitW;

    logic [VISIT_ROW_W-1:0] rows_reg  [Rows];
    logic [VISIT_ROW_W-1:0] rows_next [Rows];
    logic [RowHi-1:0]       rd_row_full;
    logic [RowHi-1:0]       wr_row_full;
    logic [VISIT_ROW_W-1:0] rd_word;

    assign rd_row_full = rd_index[INDEX_W-1:BitW];
    assign wr_row_full = wr_index[INDEX_W-1:BitW];

    // Read port: row select then bit select
    always_comb
    begin
        if (int'(rd_row_full) < Rows)
            rd_word = rows_reg[rd_row_full[RowW-1:0]];
        else
            rd_word = '0;
        rd_visited = rd_word[rd_index[BitW-1:0]];
    end

    // Clear on start, then mark the sector just entered
    always_comb
    begin
        for (int r = 0; r < Rows; r++)
        begin
            rows_next[r] = clear ? '0 : rows_reg[r];
            if (wr_en && int'(wr_row_full) == r)
                rows_next[r][wr_index[BitW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < Rows; r++)
                rows_reg[r] <= '0;
        end
        else
        begin
            for (int r = 0; r < Rows; r++)
                rows_reg[r] <= rows_next[r];
        end
    end

endmodule
